>>> design/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by the cell, the top level and the checker.
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_W        = 8;
    localparam int TIME_W      = 32;
    localparam int KEY_W       = TIME_W + 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int OCC_W       = 5;
    localparam int REQ_W       = 2;

    localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] key;
    } t_entry;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic            push;
        logic            pop;
        t_entry          new_entry;
        logic [ID_W-1:0] query_id;
    } t_cell_ctl;

endpackage

>>> design/spq_cell.sv
// One slot of the sorted queue: holds an entry and trades it with its neighbors.
// Depends on spq_pkg.
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  logic               i_occupied,
    input  logic               i_left_occupied,
    input  logic               i_left_beaten,
    input  spq_pkg::t_entry    i_left_entry,
    input  spq_pkg::t_entry    i_right_entry,
    output spq_pkg::t_entry    o_entry,
    output logic               o_beaten,
    output logic               o_match
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   new_wins;
    logic   take_left;
    logic   take_new;

    // new entry strictly ahead of this one: smaller key, or equal key and lower id
    assign new_wins = (i_ctl.new_entry.key < r_entry.key) ||
                      ((i_ctl.new_entry.key == r_entry.key) &&
                       (i_ctl.new_entry.id < r_entry.id));
    assign o_beaten = i_occupied & new_wins;

    // shift back behind the new entry, or land it in the first slot it reaches
    assign take_left = i_ctl.push & i_left_beaten;
    assign take_new  = i_ctl.push & (o_beaten | ~i_occupied) &
                       i_left_occupied & ~i_left_beaten;

    assign o_match = i_occupied & (r_entry.id == i_ctl.query_id);

    // pick the next content: from the left, the new beat, the right, or hold
    always_comb begin
        n_entry = r_entry;
        if (take_left) begin
            n_entry = i_left_entry;
        end else if (take_new) begin
            n_entry = i_ctl.new_entry;
        end else if (i_ctl.pop) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

>>> design/sorted_priority_queue_fifo_edf.sv
// Top level of the sorted priority queue: request decode, fill count, cell row.
// Depends on spq_pkg and spq_cell.
//
//  channel   | handshake              | payload
//  ----------+------------------------+---------------------------------------------
//  request   | start / busy           | i_req_type, i_entry_id, i_arrival_time,
//            |                        | i_last_service_time, i_deadline_span
//  result    | o_result_strobe        | o_result_id, o_result_valid, o_push_dropped,
//            |                        | o_occupancy
//  config    | i_cfg_we               | i_cfg_wdata (order mode)
//
// The cell row inserts, pops or searches in the cycle the beat is accepted, and the
// result is shown on the next cycle for one cycle.
// busy stays low, so a request can be accepted on every cycle.
// The synchronous reset empties the queue and selects arrival-time order.
// The result strobe cannot be stalled by the receiver.
module sorted_priority_queue_fifo_edf (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [spq_pkg::REQ_W-1:0]    i_req_type,
    input  logic [spq_pkg::ID_W-1:0]     i_entry_id,
    input  logic [spq_pkg::TIME_W-1:0]   i_arrival_time,
    input  logic [spq_pkg::TIME_W-1:0]   i_last_service_time,
    input  logic [spq_pkg::TIME_W-1:0]   i_deadline_span,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_wdata,
    output logic                         o_result_strobe,
    output logic [spq_pkg::ID_W-1:0]     o_result_id,
    output logic                         o_result_valid,
    output logic                         o_push_dropped,
    output logic [spq_pkg::OCC_W-1:0]    o_occupancy
);
    import spq_pkg::*;

    logic             r_order_mode;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_strobe;
    logic [ID_W-1:0]  r_result_id;
    logic [ID_W-1:0]  n_result_id;
    logic             r_result_valid;
    logic             n_result_valid;
    logic             r_push_dropped;
    logic             n_push_dropped;

    logic             accept;
    logic             full;
    logic             empty;
    logic [KEY_W-1:0] new_key;
    t_cell_ctl        ctl;

    t_entry                 w_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_occ;
    logic [QUEUE_DEPTH-1:0] w_beaten;
    logic [QUEUE_DEPTH-1:0] w_match;

    assign busy   = 1'b0;
    assign accept = start & ~busy;
    assign full   = (r_count == CNT_W'(QUEUE_DEPTH));
    assign empty  = (r_count == '0);

    // snapshot the key: arrival time, or deadline summed in full width
    assign new_key = r_order_mode ?
                     ({1'b0, i_last_service_time} + {1'b0, i_deadline_span}) :
                     {1'b0, i_arrival_time};

    // broadcast the command to the row
    always_comb begin
        ctl.push          = accept & (i_req_type == REQ_PUSH) & ~full;
        ctl.pop           = accept & (i_req_type == REQ_POP) & ~empty;
        ctl.new_entry.id  = i_entry_id;
        ctl.new_entry.key = new_key;
        ctl.query_id      = i_entry_id;
    end

    // build the row of cells
    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            assign w_occ[g] = (r_count > CNT_W'(g));
            if (g == 0) begin : g_head
                spq_cell u_cell (
                    .i_clk           (i_clk),
                    .i_ctl           (ctl),
                    .i_occupied      (w_occ[g]),
                    .i_left_occupied (1'b1),
                    .i_left_beaten   (1'b0),
                    .i_left_entry    (ctl.new_entry),
                    .i_right_entry   (w_entry[g+1]),
                    .o_entry         (w_entry[g]),
                    .o_beaten        (w_beaten[g]),
                    .o_match         (w_match[g])
                );
            end else if (g == QUEUE_DEPTH - 1) begin : g_tail
                spq_cell u_cell (
                    .i_clk           (i_clk),
                    .i_ctl           (ctl),
                    .i_occupied      (w_occ[g]),
                    .i_left_occupied (w_occ[g-1]),
                    .i_left_beaten   (w_beaten[g-1]),
                    .i_left_entry    (w_entry[g-1]),
                    .i_right_entry   (w_entry[g]),
                    .o_entry         (w_entry[g]),
                    .o_beaten        (w_beaten[g]),
                    .o_match         (w_match[g])
                );
            end else begin : g_mid
                spq_cell u_cell (
                    .i_clk           (i_clk),
                    .i_ctl           (ctl),
                    .i_occupied      (w_occ[g]),
                    .i_left_occupied (w_occ[g-1]),
                    .i_left_beaten   (w_beaten[g-1]),
                    .i_left_entry    (w_entry[g-1]),
                    .i_right_entry   (w_entry[g+1]),
                    .o_entry         (w_entry[g]),
                    .o_beaten        (w_beaten[g]),
                    .o_match         (w_match[g])
                );
            end
        end
    endgenerate

    // decode the result of this beat and the next fill count
    always_comb begin
        n_count        = r_count;
        n_result_id    = '0;
        n_result_valid = 1'b0;
        n_push_dropped = 1'b0;
        case (i_req_type)
            REQ_PUSH: begin
                if (full) begin
                    n_push_dropped = 1'b1;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            REQ_POP: begin
                if (!empty) begin
                    n_result_id    = w_entry[0].id;
                    n_result_valid = 1'b1;
                    n_count        = r_count - CNT_W'(1);
                end
            end
            REQ_QUERY: begin
                n_result_valid = |w_match;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // advance control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order_mode <= 1'b0;
            r_count      <= '0;
            r_strobe     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_order_mode <= i_cfg_wdata;
            end
            if (accept) begin
                r_count <= n_count;
            end
            r_strobe <= accept;
        end
    end

    // hold the result beat until the next accepted request
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result_id    <= n_result_id;
            r_result_valid <= n_result_valid;
            r_push_dropped <= n_push_dropped;
        end
    end

    assign o_result_strobe = r_strobe;
    assign o_result_id     = r_result_id;
    assign o_result_valid  = r_result_valid;
    assign o_push_dropped  = r_push_dropped;
    assign o_occupancy     = OCC_W'(r_count);

endmodule

>>> design/spq_checker.sv
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue_fifo_edf.
module spq_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic [spq_pkg::REQ_W-1:0]    i_req_type,
    input logic                         o_result_strobe,
    input logic                         o_result_valid,
    input logic                         o_push_dropped,
    input logic [spq_pkg::OCC_W-1:0]    o_occupancy
);
    import spq_pkg::*;

    // every accepted beat yields a result on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_result_strobe)
        else $error("accepted request produced no result");

    // no result without a request accepted just before
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(start && !busy))
        else $error("result without accepted request");

    // a dropped push only happens on a push against a full queue
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_push_dropped) |->
            ((o_occupancy == OCC_W'(QUEUE_DEPTH)) && ($past(i_req_type) == REQ_PUSH)))
        else $error("push dropped while queue not full");

    // a push reports no entry and no hit
    a_push_no_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && ($past(i_req_type) == REQ_PUSH)) |-> !o_result_valid)
        else $error("push reported a valid result");

endmodule

bind sorted_priority_queue_fifo_edf spq_checker u_spq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_req_type      (i_req_type),
    .o_result_strobe (o_result_strobe),
    .o_result_valid  (o_result_valid),
    .o_push_dropped  (o_push_dropped),
    .o_occupancy     (o_occupancy)
);

>>> test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sorted priority queue (arrival / deadline order).
// Depends on spq_pkg and sorted_priority_queue_fifo_edf; keeps a shadow queue to predict each result.
module tb;
    import spq_pkg::*;

    localparam logic [REQ_W-1:0] REQ_NOP        = 2'd3;
    localparam logic             MODE_ARRIVAL   = 1'b0;
    localparam logic             MODE_DEADLINE  = 1'b1;
    localparam int               CYCLE_LIMIT    = 200000;
    localparam int               DRAIN_CYCLES   = 8;

    typedef struct {
        logic [ID_W-1:0]  id;
        logic             valid;
        logic             dropped;
        logic [OCC_W-1:0] occ;
    } t_sched_result;

    logic                i_clk               = 1'b0;
    logic                i_rst_n             = 1'b0;
    logic                start               = 1'b0;
    logic [REQ_W-1:0]    i_req_type          = REQ_NOP;
    logic [ID_W-1:0]     i_entry_id          = '0;
    logic [TIME_W-1:0]   i_arrival_time      = '0;
    logic [TIME_W-1:0]   i_last_service_time = '0;
    logic [TIME_W-1:0]   i_deadline_span     = '0;
    logic                i_cfg_we            = 1'b0;
    logic                i_cfg_wdata         = 1'b0;
    logic                busy;
    logic                o_result_strobe;
    logic [ID_W-1:0]     o_result_id;
    logic                o_result_valid;
    logic                o_push_dropped;
    logic [OCC_W-1:0]    o_occupancy;

    // shadow copy of the queue contents and the order mode
    logic [ID_W-1:0]     shadow_ids  [QUEUE_DEPTH];
    logic [KEY_W-1:0]    shadow_keys [QUEUE_DEPTH];
    int                  shadow_fill = 0;
    logic                shadow_mode = MODE_ARRIVAL;

    t_sched_result       sched_results_due[$];
    int                  error_count = 0;
    int                  cycle_count = 0;
    int                  gap_pct     = 25;

    sorted_priority_queue_fifo_edf i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_req_type          (i_req_type),
        .i_entry_id          (i_entry_id),
        .i_arrival_time      (i_arrival_time),
        .i_last_service_time (i_last_service_time),
        .i_deadline_span     (i_deadline_span),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .o_result_strobe     (o_result_strobe),
        .o_result_id         (o_result_id),
        .o_result_valid      (o_result_valid),
        .o_push_dropped      (o_push_dropped),
        .o_occupancy         (o_occupancy)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // strict priority: smaller key wins, then lower id
    function automatic bit key_beats(logic [KEY_W-1:0] ka, logic [ID_W-1:0] ida,
                                     logic [KEY_W-1:0] kb, logic [ID_W-1:0] idb);
        if (ka != kb) return ka < kb;
        return ida < idb;
    endfunction

    // apply one accepted request to the shadow queue and return its result
    function automatic t_sched_result predict_sched_result(logic [REQ_W-1:0]  req,
                                                           logic [ID_W-1:0]   id,
                                                           logic [TIME_W-1:0] arr,
                                                           logic [TIME_W-1:0] lst,
                                                           logic [TIME_W-1:0] span);
        t_sched_result    res;
        logic [KEY_W-1:0] key;
        int               pos;
        res = '{id: '0, valid: 1'b0, dropped: 1'b0, occ: '0};
        case (req)
            REQ_PUSH: begin
                if (shadow_fill >= QUEUE_DEPTH) begin
                    res.dropped = 1'b1;
                end else begin
                    key = (shadow_mode == MODE_DEADLINE) ? {1'b0, lst} + {1'b0, span}
                                                         : {1'b0, arr};
                    pos = shadow_fill;
                    while (pos > 0 && key_beats(key, id, shadow_keys[pos-1], shadow_ids[pos-1]))
                    begin
                        shadow_keys[pos] = shadow_keys[pos-1];
                        shadow_ids[pos]  = shadow_ids[pos-1];
                        pos--;
                    end
                    shadow_keys[pos] = key;
                    shadow_ids[pos]  = id;
                    shadow_fill++;
                end
            end
            REQ_POP: begin
                if (shadow_fill > 0) begin
                    res.id    = shadow_ids[0];
                    res.valid = 1'b1;
                    for (int i = 0; i + 1 < shadow_fill; i++) begin
                        shadow_ids[i]  = shadow_ids[i+1];
                        shadow_keys[i] = shadow_keys[i+1];
                    end
                    shadow_fill--;
                end
            end
            REQ_QUERY: begin
                for (int i = 0; i < shadow_fill; i++)
                    if (shadow_ids[i] == id) res.valid = 1'b1;
            end
            default: ;
        endcase
        res.occ = shadow_fill[OCC_W-1:0];
        return res;
    endfunction

    // send one request beat, idling first at random, and record its result
    task automatic send_sched_req(logic [REQ_W-1:0] req, logic [ID_W-1:0] id,
                                  logic [TIME_W-1:0] arr, logic [TIME_W-1:0] lst,
                                  logic [TIME_W-1:0] span);
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start               <= 1'b1;
        i_req_type          <= req;
        i_entry_id          <= id;
        i_arrival_time      <= arr;
        i_last_service_time <= lst;
        i_deadline_span     <= span;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sched_results_due.push_back(predict_sched_result(req, id, arr, lst, span));
    endtask

    // drain, then write the order mode while the block is idle
    task automatic set_order_mode(logic mode);
        start <= 1'b0;
        @(posedge i_clk);
        while (sched_results_due.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_mode  = mode;
    endtask

    function automatic logic [TIME_W-1:0] pick_time(bit narrow);
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) return '0;
        if (sel == 1) return '1;
        if (narrow || sel < 4) return TIME_W'($urandom_range(15));
        return $urandom;
    endfunction

    // arrival order: extremes, ties broken by id, duplicates, query, no-op, empty pop
    task automatic test_arrival_order();
        gap_pct = 25;
        send_sched_req(REQ_POP,   8'h00, '0, '0, '0);
        send_sched_req(REQ_QUERY, 8'h00, '0, '0, '0);
        send_sched_req(REQ_PUSH,  8'hFF, '1, '1, '1);
        send_sched_req(REQ_PUSH,  8'h00, '0, '0, '0);
        send_sched_req(REQ_PUSH,  8'h05, 32'd100, 32'd7, 32'd9);
        send_sched_req(REQ_PUSH,  8'h03, 32'd100, '1, '0);
        send_sched_req(REQ_PUSH,  8'h05, 32'd100, '0, '1);
        send_sched_req(REQ_QUERY, 8'h05, '0, '0, '0);
        send_sched_req(REQ_QUERY, 8'h80, '1, '1, '1);
        send_sched_req(REQ_NOP,   8'hFF, '1, '1, '1);
        repeat (6) send_sched_req(REQ_POP, 8'hAA, '1, '0, '1);
    endtask

    // deadline order: 33-bit sum without loss, small keys ahead of large ones
    task automatic test_deadline_order();
        set_order_mode(MODE_DEADLINE);
        send_sched_req(REQ_PUSH, 8'h01, '0, '1, '1);
        send_sched_req(REQ_PUSH, 8'h02, '1, '0, '0);
        send_sched_req(REQ_PUSH, 8'h03, '0, '1, '0);
        send_sched_req(REQ_PUSH, 8'h04, '1, '0, 32'h8000_0000);
        repeat (4) send_sched_req(REQ_POP, 8'h00, '0, '0, '0);
    endtask

    task automatic run_traffic_phase(logic mode, int count, int push_pct, int pop_pct,
                                     int gaps, bit narrow);
        int               sel;
        logic [REQ_W-1:0] req;
        logic [ID_W-1:0]  id;
        set_order_mode(mode);
        gap_pct = gaps;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            if (sel < push_pct)                req = REQ_PUSH;
            else if (sel < push_pct + pop_pct) req = REQ_POP;
            else if (sel < 97)                 req = REQ_QUERY;
            else                               req = REQ_NOP;
            id = narrow ? ID_W'($urandom_range(7)) : ID_W'($urandom_range(255));
            // look up a held id most of the time so queries hit
            if (req == REQ_QUERY && shadow_fill > 0 && $urandom_range(99) < 60)
                id = shadow_ids[$urandom_range(shadow_fill - 1)];
            send_sched_req(req, id, pick_time(narrow), pick_time(narrow), pick_time(narrow));
        end
    endtask

    // random traffic in both modes, mode changes while entries are held
    task automatic test_random_traffic();
        run_traffic_phase(MODE_ARRIVAL,  150, 45, 35, 25, 1'b0);
        run_traffic_phase(MODE_DEADLINE, 150, 70, 15, 25, 1'b1);
        run_traffic_phase(MODE_ARRIVAL,  200, 45, 35,  0, 1'b1);
        run_traffic_phase(MODE_DEADLINE, 100, 20, 65, 25, 1'b0);
        run_traffic_phase(MODE_DEADLINE, 150, 45, 35, 25, 1'b1);
        run_traffic_phase(MODE_ARRIVAL,  100, 70, 15, 25, 1'b1);
        run_traffic_phase(MODE_DEADLINE, 100, 45, 35,  0, 1'b0);
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // compare each result beat against the oldest prediction
    always @(posedge i_clk) begin
        t_sched_result want;
        if (i_rst_n && o_result_strobe) begin
            if (sched_results_due.size() == 0) begin
                $display("%0t ns: unexpected result beat, actual id %0h valid %0b", $time,
                         o_result_id, o_result_valid);
                error_count++;
            end else begin
                want = sched_results_due.pop_front();
                check_field("result_id",    32'(want.id),      32'(o_result_id));
                check_field("result_valid", 32'(want.valid),   32'(o_result_valid));
                check_field("push_dropped", 32'(want.dropped), 32'(o_push_dropped));
                check_field("occupancy",    32'(want.occ),     32'(o_occupancy));
            end
        end
    end

    // stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_arrival_order();
        test_deadline_order();
        test_random_traffic();
        start <= 1'b0;
        @(posedge i_clk);
        while (sched_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
